>>> design/kic_pkg.sv
`timescale 1ns / 1ps

package kic_pkg;

  localparam int unsigned WINDOW_LEN_DEFAULT = 10;

  // Longest keyword in either dictionary, in bytes.
  localparam int unsigned KW_MAX_LEN = 10;
  localparam int unsigned KW_BITS = KW_MAX_LEN * 8;

  localparam int unsigned LOGIC_COUNT = 26;
  localparam int unsigned CREATIVE_COUNT = 23;

  // Keywords are right-aligned: the last letter sits in the low byte, the
  // unused upper bytes are zero.
  localparam logic [KW_BITS-1:0] LOGIC_WORDS [LOGIC_COUNT] = '{
    KW_BITS'("plus"), KW_BITS'("minus"), KW_BITS'("times"), KW_BITS'("multiply"),
    KW_BITS'("divide"), KW_BITS'("compute"), KW_BITS'("calculate"),
    KW_BITS'("crc8"), KW_BITS'("crc"), KW_BITS'("increment"), KW_BITS'("mod256"),
    KW_BITS'("hash"), KW_BITS'("exact"), KW_BITS'("verify"), KW_BITS'("lookup"),
    KW_BITS'("year"), KW_BITS'("add"), KW_BITS'("subtract"), KW_BITS'("sum"),
    KW_BITS'("product"), KW_BITS'("modulo"), KW_BITS'("wiki"), KW_BITS'("fact"),
    KW_BITS'("true"), KW_BITS'("false"), KW_BITS'("equals")
  };

  localparam logic [KW_BITS-1:0] CREATIVE_WORDS [CREATIVE_COUNT] = '{
    KW_BITS'("poem"), KW_BITS'("haiku"), KW_BITS'("story"), KW_BITS'("imagine"),
    KW_BITS'("invent"), KW_BITS'("joke"), KW_BITS'("write"), KW_BITS'("draft"),
    KW_BITS'("brainstorm"), KW_BITS'("creative"), KW_BITS'("fiction"),
    KW_BITS'("song"), KW_BITS'("lyrics"), KW_BITS'("metaphor"), KW_BITS'("riddle"),
    KW_BITS'("roleplay"), KW_BITS'("pretend"), KW_BITS'("dream"), KW_BITS'("paint"),
    KW_BITS'("narrate"), KW_BITS'("essay"), KW_BITS'("opine"), KW_BITS'("rhyme")
  };

  typedef enum logic [1:0] {
    INTENT_UNKNOWN  = 2'd0,
    INTENT_LOGIC    = 2'd1,
    INTENT_CREATIVE = 2'd2,
    INTENT_MIXED    = 2'd3
  } intent_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_char;
    logic       end_of_turn;
  } char_item_t;

  typedef struct packed {
    intent_t intent;
    logic    logic_seen;
    logic    creative_seen;
  } intent_result_t;

  typedef struct packed {
    logic logic_hit;
    logic creative_hit;
  } kic_hits_t;

  // True when the keyword ends at the newest byte (low byte) of the window.
  function automatic logic word_ends(input logic [KW_BITS-1:0] win,
                                     input logic [KW_BITS-1:0] kw);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < KW_MAX_LEN; k++) begin
      if (kw[k*8 +: 8] != 8'd0 && win[k*8 +: 8] != kw[k*8 +: 8]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return c + 8'd32;
    end
    return c;
  endfunction

endpackage

>>> design/kic_match.sv
`timescale 1ns / 1ps

module kic_match import kic_pkg::*; #(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEFAULT
) (
  input  logic [WINDOW_LEN*8-1:0] window,
  output kic_hits_t               hits
);

  logic [KW_BITS-1:0] recent_win;

  // Keywords never exceed KW_MAX_LEN bytes, so only the newest bytes matter.
  assign recent_win = window[KW_BITS-1:0];

  always_comb begin
    hits = '0;
    for (int i = 0; i < LOGIC_COUNT; i++) begin
      if (word_ends(recent_win, LOGIC_WORDS[i])) begin
        hits.logic_hit = 1'b1;
      end
    end
    for (int i = 0; i < CREATIVE_COUNT; i++) begin
      if (word_ends(recent_win, CREATIVE_WORDS[i])) begin
        hits.creative_hit = 1'b1;
      end
    end
  end

endmodule

>>> design/keyword_intent_classifier.sv
`timescale 1ns / 1ps

// Keyword intent classifier. Feed a text turn one byte per transfer on the
// char channel; mark the last byte with end_of_turn (or send end_of_turn with
// has_char low to close a turn, which for an empty turn gives unknown). Each
// byte is lowercased (A-Z only) and, with the WINDOW_LEN-1 bytes before it,
// compared against fixed logic and creative keyword lists, so keywords match
// case-insensitively anywhere in the turn. A digit together with an operator
// ('+', '*', '=' anywhere, or '-' after a digit) also counts as logic. One
// result transfer (intent, logic_seen, creative_seen) follows each end of
// turn, after which the window and flags are cleared. Throughput is one byte
// per cycle unless the char channel stalls: an item sits in one input register,
// the parallel keyword compare and the flag update run combinationally on the
// history register and the staged byte, and the result lands in an output
// register after the input register. The char channel stalls only when an
// end of turn item waits behind a result that is itself stalled.
module keyword_intent_classifier import kic_pkg::*; #(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           char_valid,
  output logic           char_stall,
  input  char_item_t     char_item,
  output logic           intent_valid,
  input  logic           intent_stall,
  output intent_result_t intent_result
);

  localparam int unsigned HIST_BITS = (WINDOW_LEN - 1) * 8;

  // Input register
  logic       stage_valid;
  char_item_t stage;

  // Per-turn state
  logic [HIST_BITS-1:0] recent;
  logic                 logic_flag;
  logic                 creative_flag;
  logic                 digit_flag;
  logic                 operator_flag;

  logic [HIST_BITS-1:0] recent_next;
  logic                 logic_flag_next;
  logic                 creative_flag_next;
  logic                 digit_flag_next;
  logic                 operator_flag_next;

  logic                   out_free;
  logic                   stage_go;
  logic [7:0]             lower_char;
  logic [WINDOW_LEN*8-1:0] window;
  kic_hits_t              hits;
  logic                   logic_any;
  intent_result_t         result_next;

  // Handshake: the stage advances unless it holds an end of turn and the
  // result register cannot take a new result this cycle.
  assign out_free   = !intent_valid || !intent_stall;
  assign stage_go   = stage_valid && (!stage.end_of_turn || out_free);
  assign char_stall = stage_valid && !stage_go;

  // Newest byte in the low byte of the window.
  assign lower_char = to_lower(stage.char_byte);
  assign window     = {recent, lower_char};

  kic_match #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_match (
    .window(window),
    .hits  (hits)
  );

  always_comb begin
    recent_next        = recent;
    logic_flag_next    = logic_flag;
    creative_flag_next = creative_flag;
    digit_flag_next    = digit_flag;
    operator_flag_next = operator_flag;

    if (stage.has_char) begin
      recent_next        = window[HIST_BITS-1:0];
      logic_flag_next    = logic_flag || hits.logic_hit;
      creative_flag_next = creative_flag || hits.creative_hit;
      digit_flag_next    = digit_flag || (lower_char >= "0" && lower_char <= "9");
      // A minus counts only once a digit has been seen earlier in the turn.
      if (lower_char == "+" || lower_char == "*" || lower_char == "=" ||
          (lower_char == "-" && digit_flag)) begin
        operator_flag_next = 1'b1;
      end
    end

    // Classify from the flags as updated by this item.
    logic_any = logic_flag_next || (digit_flag_next && operator_flag_next);
    result_next.logic_seen    = logic_any;
    result_next.creative_seen = creative_flag_next;
    if (logic_any && creative_flag_next) begin
      result_next.intent = INTENT_MIXED;
    end else if (logic_any) begin
      result_next.intent = INTENT_LOGIC;
    end else if (creative_flag_next) begin
      result_next.intent = INTENT_CREATIVE;
    end else begin
      result_next.intent = INTENT_UNKNOWN;
    end
  end

  // Input register: load on every transfer, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!char_stall) begin
      stage_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall) begin
      stage <= char_item;
    end
  end

  // Turn state: advance on each processed item, clear after end of turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      recent        <= '0;
      logic_flag    <= 1'b0;
      creative_flag <= 1'b0;
      digit_flag    <= 1'b0;
      operator_flag <= 1'b0;
    end else if (stage_go) begin
      if (stage.end_of_turn) begin
        recent        <= '0;
        logic_flag    <= 1'b0;
        creative_flag <= 1'b0;
        digit_flag    <= 1'b0;
        operator_flag <= 1'b0;
      end else begin
        recent        <= recent_next;
        logic_flag    <= logic_flag_next;
        creative_flag <= creative_flag_next;
        digit_flag    <= digit_flag_next;
        operator_flag <= operator_flag_next;
      end
    end
  end

  // Result register: fill on end of turn, drop once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      intent_valid <= 1'b0;
    end else if (stage_go && stage.end_of_turn) begin
      intent_valid <= 1'b1;
    end else if (!intent_stall) begin
      intent_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && stage.end_of_turn) begin
      intent_result <= result_next;
    end
  end

endmodule
